// ===== src/rsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control types of the RPN stack calculator.
package rsc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int WORD_W = 32;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 2;
   localparam int ENTRIES_W = 7;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUB    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MUL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIV    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FINISH = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

   typedef struct packed {
      logic load;
      logic pop_right;
      logic pop_left;
      logic calc;
      logic div_start;
      logic div_step;
      logic div_fix;
      logic put;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              right_zero;
   } stat_type;

endpackage

// ===== src/rsc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response transactions.
interface rsc_req_if;
   logic                               valid;
   logic                               ready;
   logic [rsc_pkg::KIND_W-1:0]         kind;
   logic signed [rsc_pkg::WORD_W-1:0]  operand;

   modport source (output valid, output kind, output operand, input ready);
   modport sink (input valid, input kind, input operand, output ready);
endinterface

interface rsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rsc_pkg::WORD_W-1:0]   result;
   logic [rsc_pkg::STATUS_W-1:0]        status;
   logic [rsc_pkg::ENTRIES_W-1:0]       entries;

   modport source (output valid, output result, output status, output entries, input ready);
   modport sink (input valid, input result, input status, input entries, output ready);
endinterface

// ===== src/rpn_stack_calculator_core.sv =====
`timescale 1ns / 1ps
// Top level of the RPN stack calculator: controller, datapath and channel ports.
// The block handles one request transaction at a time. A push passes S_PUT and a finish
// S_POP_R; add, subtract and multiply pop both operands, calculate and put, and a divide also
// runs the one-bit-per-cycle shift-subtract divider. A wait state splits the pops because the
// stack memory read is registered. A new request is accepted while the previous response still
// waits in its output register. The stack needs no clearing pass.
module rpn_stack_calculator_core #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   rsc_req_if.sink      req_ch,
   rsc_rsp_if.source    rsp_ch
);

   rsc_pkg::cmd_type  cmd;
   rsc_pkg::stat_type stat;

   rsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_kind  (req_ch.kind),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req_ch.kind),
      .req_operand (req_ch.operand),
      .rsp_result  (rsp_ch.result),
      .rsp_status  (rsp_ch.status),
      .rsp_entries (rsp_ch.entries)
   );

endmodule

// ===== src/rsc_divider.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, one restoring shift-subtract step per cycle while step is high.
module rsc_divider (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [rsc_pkg::WORD_W-1:0]  numer,
   input  logic [rsc_pkg::WORD_W-1:0]  denom,
   output logic [rsc_pkg::WORD_W-1:0]  quotient
);

   logic [rsc_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [rsc_pkg::WORD_W-1:0] quo_ff, quo_in;
   logic [rsc_pkg::WORD_W-1:0] den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [rsc_pkg::WORD_W:0]   shifted;
   logic [rsc_pkg::WORD_W:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[rsc_pkg::WORD_W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = numer[rsc_pkg::WORD_W-1] ? (~numer + 1'b1) : numer;
         den_in = denom[rsc_pkg::WORD_W-1] ? (~denom + 1'b1) : denom;
         neg_in = numer[rsc_pkg::WORD_W-1] ^ denom[rsc_pkg::WORD_W-1];
      end else if (step) begin
         if (!diff[rsc_pkg::WORD_W]) begin
            rem_in = diff[rsc_pkg::WORD_W-1:0];
            quo_in = {quo_ff[rsc_pkg::WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[rsc_pkg::WORD_W-1:0];
            quo_in = {quo_ff[rsc_pkg::WORD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ===== src/rsc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: stack memory, stack pointer, operand registers, ALU and response registers.
module rsc_datapath #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsc_pkg::cmd_type                    cmd,
   output rsc_pkg::stat_type                   stat,
   input  logic [rsc_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [rsc_pkg::WORD_W-1:0]   req_operand,
   output logic signed [rsc_pkg::WORD_W-1:0]   rsp_result,
   output logic [rsc_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rsc_pkg::ENTRIES_W-1:0]       rsp_entries
);

   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SpW = $clog2(STACK_DEPTH + 1);

   logic [rsc_pkg::WORD_W-1:0] mem [STACK_DEPTH];
   logic [rsc_pkg::WORD_W-1:0] rd_data_ff;
   logic [AddrW-1:0]           rd_addr;

   logic [SpW-1:0]              sp_ff, sp_in;
   logic [rsc_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [rsc_pkg::WORD_W-1:0]  operand_ff, operand_in;
   logic [rsc_pkg::WORD_W-1:0]  right_ff, right_in;
   logic [rsc_pkg::WORD_W-1:0]  left_ff, left_in;
   logic [rsc_pkg::WORD_W-1:0]  res_ff, res_in;
   logic                        under_ff, under_in;
   logic                        over_ff, over_in;
   logic                        divz_ff, divz_in;
   logic [rsc_pkg::WORD_W-1:0]  result_ff, result_in;
   logic [rsc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [rsc_pkg::ENTRIES_W-1:0] entries_ff, entries_in;

   logic                        sp_empty;
   logic                        sp_full;
   logic                        wr_en;
   logic [rsc_pkg::WORD_W-1:0]  wr_data;
   logic [rsc_pkg::WORD_W-1:0]  quotient;

   assign sp_empty = (sp_ff == '0);
   assign sp_full  = (sp_ff >= SpW'(STACK_DEPTH));
   assign rd_addr  = AddrW'(sp_ff - 1'b1);
   assign wr_en    = cmd.put && !sp_full;
   assign wr_data  = (kind_ff == rsc_pkg::KIND_PUSH) ? operand_ff : res_ff;

   assign stat.kind       = kind_ff;
   assign stat.right_zero = (right_ff == '0);

   rsc_divider u_divider (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .numer    (left_ff),
      .denom    (right_ff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[sp_ff[AddrW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      sp_in      = sp_ff;
      kind_in    = kind_ff;
      operand_in = operand_ff;
      right_in   = right_ff;
      left_in    = left_ff;
      res_in     = res_ff;
      under_in   = under_ff;
      over_in    = over_ff;
      divz_in    = divz_ff;
      result_in  = result_ff;
      status_in  = status_ff;
      entries_in = entries_ff;

      if (cmd.load) begin
         kind_in    = req_kind;
         operand_in = req_operand;
         res_in     = '0;
         under_in   = 1'b0;
         over_in    = 1'b0;
         divz_in    = 1'b0;
      end
      if (cmd.pop_right) begin
         right_in = sp_empty ? '0 : rd_data_ff;
         under_in = sp_empty;
         if (!sp_empty) begin
            sp_in = sp_ff - 1'b1;
         end
      end
      if (cmd.pop_left) begin
         left_in = sp_empty ? '0 : rd_data_ff;
         under_in = under_ff | sp_empty;
         if (!sp_empty) begin
            sp_in = sp_ff - 1'b1;
         end
      end
      if (cmd.calc) begin
         unique case (kind_ff)
            rsc_pkg::KIND_ADD: res_in = left_ff + right_ff;
            rsc_pkg::KIND_SUB: res_in = left_ff - right_ff;
            rsc_pkg::KIND_MUL: res_in = left_ff * right_ff;
            default: begin
               res_in  = '0;
               divz_in = (kind_ff == rsc_pkg::KIND_DIV) && (right_ff == '0);
            end
         endcase
      end
      if (cmd.div_fix) begin
         res_in = quotient;
      end
      if (cmd.put) begin
         if (!sp_full) begin
            sp_in = sp_ff + 1'b1;
         end else if (kind_ff == rsc_pkg::KIND_PUSH) begin
            over_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         priority if (kind_ff == rsc_pkg::KIND_PUSH) begin
            result_in = operand_ff;
         end else if (kind_ff == rsc_pkg::KIND_FINISH) begin
            result_in = right_ff;
         end else begin
            result_in = res_ff;
         end
         priority if (divz_ff) begin
            status_in = rsc_pkg::ST_DIVZ;
         end else if (over_ff) begin
            status_in = rsc_pkg::ST_OVER;
         end else if (under_ff) begin
            status_in = rsc_pkg::ST_UNDER;
         end else begin
            status_in = rsc_pkg::ST_OK;
         end
         entries_in = rsc_pkg::ENTRIES_W'(sp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
      kind_ff    <= kind_in;
      operand_ff <= operand_in;
      right_ff   <= right_in;
      left_ff    <= left_in;
      res_ff     <= res_in;
      under_ff   <= under_in;
      over_ff    <= over_in;
      divz_ff    <= divz_in;
      result_ff  <= result_in;
      status_ff  <= status_in;
      entries_ff <= entries_in;
   end

   assign rsp_result  = result_ff;
   assign rsp_status  = status_ff;
   assign rsp_entries = entries_ff;

endmodule

// ===== src/rsc_controller.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences each request transaction through the datapath.
module rsc_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rsc_pkg::KIND_W-1:0]  req_kind,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  rsc_pkg::stat_type           stat,
   output rsc_pkg::cmd_type            cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_POP_R = 4'd1;
   localparam logic [3:0] S_WAIT  = 4'd2;
   localparam logic [3:0] S_POP_L = 4'd3;
   localparam logic [3:0] S_CALC  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_FIX   = 4'd6;
   localparam logic [3:0] S_PUT   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]                     state_ff, state_in;
   logic [rsc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accept;
   logic                           slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               priority if (req_kind == rsc_pkg::KIND_PUSH) begin
                  state_in = S_PUT;
               end else if (req_kind == rsc_pkg::KIND_ADD || req_kind == rsc_pkg::KIND_SUB ||
                            req_kind == rsc_pkg::KIND_MUL || req_kind == rsc_pkg::KIND_DIV ||
                            req_kind == rsc_pkg::KIND_FINISH) begin
                  state_in = S_POP_R;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP_R: begin
            cmd.pop_right = 1'b1;
            state_in = (stat.kind == rsc_pkg::KIND_FINISH) ? S_DONE : S_WAIT;
         end
         S_WAIT: begin
            state_in = S_POP_L;
         end
         S_POP_L: begin
            cmd.pop_left = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            if (stat.kind == rsc_pkg::KIND_DIV) begin
               if (stat.right_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.div_start = 1'b1;
                  cnt_in = '0;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_PUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.div_fix = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            cmd.put = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted but controller stayed idle");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("response emitted without raising valid");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_fix_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && (state_in == S_FIX)
         |-> cnt_ff == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1))
      else $error("divider left before all steps were done");

   a_one_cmd_pop: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pop_right, cmd.pop_left, cmd.put, cmd.emit, cmd.load}))
      else $error("conflicting stack commands in one cycle");

endmodule

// ===== tb/rpn_stack_calculator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RPN stack calculator core, with a stack-tracking scoreboard.
module rpn_stack_calculator_core_tb;

   localparam int CLK_PERIOD = 20;
   localparam int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEFAULT;
   localparam logic [rsc_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [rsc_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef logic [rsc_pkg::KIND_W-1:0] kind_type;
   typedef logic [rsc_pkg::WORD_W-1:0] word_type;

   typedef struct packed {
      logic [rsc_pkg::WORD_W-1:0]    result;
      logic [rsc_pkg::STATUS_W-1:0]  status;
      logic [rsc_pkg::ENTRIES_W-1:0] entries;
   } rsp_fields_type;

   class calc_board;
      rsp_fields_type awaited[$];
      word_type       stack_words [STACK_DEPTH];
      int unsigned    depth_used;
      int unsigned    req_count;
      int unsigned    rsp_count;
      int unsigned    fail_count;
      int unsigned    status_seen [4];

      function new();
         depth_used = 0;
         req_count = 0;
         rsp_count = 0;
         fail_count = 0;
      endfunction

      function word_type pop_word(inout bit under);
         if (depth_used == 0) begin
            under = 1'b1;
            return '0;
         end
         depth_used--;
         return stack_words[depth_used];
      endfunction

      function word_type trunc_quotient(word_type num, word_type den);
         word_type num_mag;
         word_type den_mag;
         word_type quot;
         num_mag = num[rsc_pkg::WORD_W-1] ? -num : num;
         den_mag = den[rsc_pkg::WORD_W-1] ? -den : den;
         quot = num_mag / den_mag;
         return (num[rsc_pkg::WORD_W-1] != den[rsc_pkg::WORD_W-1]) ? -quot : quot;
      endfunction

      function void accept_req(kind_type kind, word_type operand);
         rsp_fields_type exp_rsp;
         word_type       right_word;
         word_type       left_word;
         bit             under;
         exp_rsp = '0;
         under = 1'b0;
         case (kind)
            rsc_pkg::KIND_PUSH: begin
               exp_rsp.result = operand;
               if (depth_used < STACK_DEPTH) begin
                  stack_words[depth_used] = operand;
                  depth_used++;
               end else begin
                  exp_rsp.status = rsc_pkg::ST_OVER;
               end
            end
            rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB, rsc_pkg::KIND_MUL, rsc_pkg::KIND_DIV: begin
               right_word = pop_word(under);
               left_word = pop_word(under);
               if (kind == rsc_pkg::KIND_DIV && right_word == '0) begin
                  exp_rsp.status = rsc_pkg::ST_DIVZ;
               end else begin
                  case (kind)
                     rsc_pkg::KIND_ADD: exp_rsp.result = left_word + right_word;
                     rsc_pkg::KIND_SUB: exp_rsp.result = left_word - right_word;
                     rsc_pkg::KIND_MUL: exp_rsp.result = left_word * right_word;
                     default:  exp_rsp.result = trunc_quotient(left_word, right_word);
                  endcase
                  stack_words[depth_used] = exp_rsp.result;
                  depth_used++;
                  if (under) exp_rsp.status = rsc_pkg::ST_UNDER;
               end
            end
            rsc_pkg::KIND_FINISH: begin
               exp_rsp.result = pop_word(under);
               if (under) exp_rsp.status = rsc_pkg::ST_UNDER;
            end
            default: ;
         endcase
         exp_rsp.entries = depth_used[rsc_pkg::ENTRIES_W-1:0];
         status_seen[exp_rsp.status]++;
         req_count++;
         awaited.push_back(exp_rsp);
      endfunction

      function void compare_rsp(word_type result, logic [rsc_pkg::STATUS_W-1:0] status,
                                logic [rsc_pkg::ENTRIES_W-1:0] entries);
         rsp_fields_type exp_rsp;
         rsp_count++;
         if (awaited.size() == 0) begin
            $error("unexpected response transaction: result %0d status %0d entries %0d",
                   $signed(result), status, entries);
            fail_count++;
            return;
         end
         exp_rsp = awaited.pop_front();
         if (result !== exp_rsp.result) begin
            $error("result mismatch: expected %0d, actual %0d",
                   $signed(exp_rsp.result), $signed(result));
            fail_count++;
         end
         if (status !== exp_rsp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_rsp.status, status);
            fail_count++;
         end
         if (entries !== exp_rsp.entries) begin
            $error("entries mismatch: expected %0d, actual %0d", exp_rsp.entries, entries);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   calc_board   board;

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   rpn_stack_calculator_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.compare_rsp(rsp_ch.result, rsp_ch.status, rsp_ch.entries);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic word_type pick_operand();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return '1;
               3:       return 32'd1;
               default: return '0;
            endcase
         end
         1, 2, 3: return $urandom_range(20) - 10;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input kind_type kind, input word_type operand);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.operand <= operand;
      do @(posedge clock); while (!req_ch.ready);
      board.accept_req(kind, operand);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
   endtask

   task automatic run_directed();
      send_item(rsc_pkg::KIND_FINISH, 32'd5);
      send_item(rsc_pkg::KIND_ADD, 32'd0);
      send_item(rsc_pkg::KIND_DIV, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, 32'h7fff_ffff);
      send_item(rsc_pkg::KIND_PUSH, 32'd1);
      send_item(rsc_pkg::KIND_ADD, '1);
      send_item(rsc_pkg::KIND_PUSH, '1);
      send_item(rsc_pkg::KIND_DIV, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, 32'd7);
      send_item(rsc_pkg::KIND_SUB, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, -32'sd2);
      send_item(rsc_pkg::KIND_MUL, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, -32'sd7);
      send_item(rsc_pkg::KIND_PUSH, 32'd2);
      send_item(rsc_pkg::KIND_DIV, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, 32'd7);
      send_item(rsc_pkg::KIND_PUSH, -32'sd2);
      send_item(rsc_pkg::KIND_DIV, 32'd0);
      send_item(rsc_pkg::KIND_PUSH, 32'd5);
      send_item(rsc_pkg::KIND_PUSH, 32'd0);
      send_item(rsc_pkg::KIND_DIV, 32'd0);
      send_item(KIND_SPARE_LO, 32'h8000_0000);
      send_item(KIND_SPARE_HI, '1);
      send_item(rsc_pkg::KIND_FINISH, 32'd0);
      send_item(rsc_pkg::KIND_FINISH, 32'd0);
      send_item(rsc_pkg::KIND_FINISH, 32'd0);
   endtask

   task automatic run_random(input int unsigned n_items);
      kind_type    kind;
      int unsigned roll;
      int unsigned push_share;
      repeat (n_items) begin
         roll = $urandom_range(99);
         push_share = (board.depth_used < 2) ? 80 : (board.depth_used > 56) ? 30 : 50;
         if (roll < 4)
            kind = kind_type'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         else if (roll < push_share)
            kind = rsc_pkg::KIND_PUSH;
         else if (roll < 92)
            kind = kind_type'($urandom_range(rsc_pkg::KIND_ADD, rsc_pkg::KIND_DIV));
         else
            kind = rsc_pkg::KIND_FINISH;
         send_item(kind, pick_operand());
      end
   endtask

   task automatic fill_stack();
      while (board.depth_used < STACK_DEPTH) send_item(rsc_pkg::KIND_PUSH, pick_operand());
      repeat (3) send_item(rsc_pkg::KIND_PUSH, pick_operand());
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      run_random(240);
      fill_stack();
      run_random(240);
   endtask

   initial begin
      board = new();
      send_idle_pct = 24;
      recv_idle_pct = 75;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= rsc_pkg::KIND_PUSH;
      req_ch.operand <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(24, 75);
      wait_drained();
      run_phase(75, 24);
      wait_drained();
      run_phase(0, 0);
      wait_drained();
      repeat (48) @(posedge clock);
      $display("Run covered %0d request and %0d response transactions over three idling phases.",
               board.req_count, board.rsp_count);
      $display("Statuses seen: ok %0d, underflow %0d, divide by zero %0d, overflow %0d.",
               board.status_seen[rsc_pkg::ST_OK], board.status_seen[rsc_pkg::ST_UNDER],
               board.status_seen[rsc_pkg::ST_DIVZ], board.status_seen[rsc_pkg::ST_OVER]);
      if (board.fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
src/rsc_pkg.sv
src/rsc_if.sv
src/rsc_divider.sv
src/rsc_datapath.sv
src/rsc_controller.sv
src/rpn_stack_calculator_core.sv
tb/rpn_stack_calculator_core_tb.sv
